>>> sv/wkdm_pkg.sv
// ----------------------------------------------------------------------------
// wkdm_pkg
// Shared types, constants and helpers for the word classifier and encoder.
// ----------------------------------------------------------------------------
package wkdm_pkg;

  localparam int WORD_W         = 32;
  localparam int HASH_BITS_DEF  = 8;
  localparam int WORDS_PER_PAGE = 1024;
  localparam int CNT_W          = 11;
  localparam int LEN_W          = 13;
  localparam int LEN_SUM_W      = 15;
  localparam int IDX_CODE_W     = 8;
  localparam int OUT_DATA_W     = 88;
  localparam int OUT_USER_W     = 3;

  localparam logic [WORD_W-1:0]    HASH_MUL  = 32'h9E37_79B1;
  localparam logic [CNT_W-1:0]     CNT_MAX   = 11'h7FF;
  localparam logic [LEN_SUM_W-1:0] LEN_MAX   = 15'd8191;
  localparam logic [LEN_SUM_W-1:0] LEN_LIMIT = 15'd4096;
  localparam logic [LEN_SUM_W-1:0] LEN_BASE  = LEN_SUM_W'(6 + WORDS_PER_PAGE / 4);

  typedef logic [1:0] tag_t;
  localparam tag_t TAG_BLANK = 2'd0;
  localparam tag_t TAG_HIT0  = 2'd1;
  localparam tag_t TAG_HIT1  = 2'd2;
  localparam tag_t TAG_NEW   = 2'd3;

  typedef struct packed {
    tag_t                    tag;
    logic [IDX_CODE_W-1:0]   index_code;
    logic [WORD_W-1:0]       miss_code;
  } word_res_t;

  typedef struct packed {
    logic [CNT_W-1:0] way0_count;
    logic [CNT_W-1:0] way1_count;
    logic [CNT_W-1:0] miss_count;
    logic             nonzero;
  } page_sum_t;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

>>> sv/wkdm_ram.sv
// ----------------------------------------------------------------------------
// wkdm_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module wkdm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/wkdm_front.sv
// ----------------------------------------------------------------------------
// wkdm_front
// Input register and multiplicative hash of the held word into a bucket.
// ----------------------------------------------------------------------------
module wkdm_front import wkdm_pkg::*; #(
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [WORD_W-1:0]    in_word,
  input  logic                 in_last,
  output logic                 in_ready,
  input  logic                 b_take,
  output logic                 a_adv,
  output logic [WORD_W-1:0]    a_word,
  output logic                 a_last,
  output logic [HASH_BITS-1:0] a_bucket
);

  logic              a_valid_r, a_valid_nxt;
  logic [WORD_W-1:0] a_word_r;
  logic              a_last_r;
  logic [WORD_W-1:0] prod;

  assign a_adv       = a_valid_r && b_take;
  assign in_ready    = !a_valid_r || b_take;
  assign a_valid_nxt = in_ready ? in_valid : a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_word_r <= in_word;
      a_last_r <= in_last;
    end
  end

  // low 32 bits of the product, bucket from the top bits
  assign prod     = a_word_r * HASH_MUL;
  assign a_bucket = prod[WORD_W-1 -: HASH_BITS];
  assign a_word   = a_word_r;
  assign a_last   = a_last_r;

endmodule

>>> sv/wkdm_classify.sv
// ----------------------------------------------------------------------------
// wkdm_classify
// Dictionary lookup, tag decision, delta coding and per-page state.
// ----------------------------------------------------------------------------
module wkdm_classify import wkdm_pkg::*; #(
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   a_adv,
  input  logic [WORD_W-1:0]      a_word,
  input  logic                   a_last,
  input  logic [HASH_BITS-1:0]   a_bucket,
  input  logic [2*WORD_W-1:0]    ram_q,
  input  logic                   single_way,
  input  logic                   emit_ready,
  output logic                   b_take,
  output logic                   ram_we,
  output logic [HASH_BITS-1:0]   ram_waddr,
  output logic [2*WORD_W-1:0]    ram_wdata,
  output logic                   word_fire,
  output logic                   word_last,
  output word_res_t              word_res,
  output page_sum_t              page_sum
);

  localparam int NB = 2 ** HASH_BITS;
  localparam int DW = (HASH_BITS > IDX_CODE_W) ? HASH_BITS : IDX_CODE_W;

  logic                 b_valid_r, b_valid_nxt;
  logic [WORD_W-1:0]    b_word_r;
  logic                 b_last_r;
  logic [HASH_BITS-1:0] b_bucket_r;
  logic                 fwd_r, fwd_nxt;
  logic [WORD_W-1:0]    fwd_way0_r, fwd_way1_r;
  logic                 touched_r [NB];
  logic                 touched_q_r, touched_q_nxt;
  logic [HASH_BITS-1:0] prev0_r, prev0_nxt;
  logic [HASH_BITS-1:0] prev1_r, prev1_nxt;
  logic [WORD_W-1:0]    prev_miss_r, prev_miss_nxt;
  logic [CNT_W-1:0]     h0_r, h0_nxt, h0_upd;
  logic [CNT_W-1:0]     h1_r, h1_nxt, h1_upd;
  logic [CNT_W-1:0]     m_r, m_nxt, m_upd;
  logic                 nz_r, nz_nxt, nz_upd;

  logic [WORD_W-1:0]    way0, way1;
  logic                 nz, hit0, hit1, miss, wr;
  logic [HASH_BITS-1:0] delta;
  logic [DW-1:0]        delta_ext;
  logic                 b_fire;

  assign b_fire = b_valid_r && emit_ready;
  assign b_take = !b_valid_r || b_fire;

  // untouched bucket reads as empty, a zero way never matches a nonzero word
  assign way0 = !touched_q_r ? '0 : fwd_r ? fwd_way0_r : ram_q[2*WORD_W-1:WORD_W];
  assign way1 = !touched_q_r ? '0 : fwd_r ? fwd_way1_r : ram_q[WORD_W-1:0];

  assign nz   = (b_word_r != '0);
  assign hit0 = nz && (way0 == b_word_r);
  assign hit1 = nz && !hit0 && !single_way && (way1 == b_word_r);
  assign miss = nz && !hit0 && !hit1;
  assign wr   = hit1 || miss;

  assign ram_we    = b_fire && wr;
  assign ram_waddr = b_bucket_r;
  assign ram_wdata = {b_word_r, way0};

  assign delta     = b_bucket_r ^ (hit1 ? prev1_r : prev0_r);
  assign delta_ext = DW'(delta);

  always_comb begin
    word_res            = '0;
    word_res.tag        = TAG_BLANK;
    if (hit0) begin
      word_res.tag        = TAG_HIT0;
      word_res.index_code = delta_ext[IDX_CODE_W-1:0];
    end else if (hit1) begin
      word_res.tag        = TAG_HIT1;
      word_res.index_code = delta_ext[IDX_CODE_W-1:0];
    end else if (miss) begin
      word_res.tag        = TAG_NEW;
      word_res.miss_code  = b_word_r ^ prev_miss_r;
    end
  end

  assign h0_upd = hit0 ? bump(h0_r) : h0_r;
  assign h1_upd = hit1 ? bump(h1_r) : h1_r;
  assign m_upd  = miss ? bump(m_r) : m_r;
  assign nz_upd = nz_r || nz;

  assign page_sum.way0_count = h0_upd;
  assign page_sum.way1_count = h1_upd;
  assign page_sum.miss_count = m_upd;
  assign page_sum.nonzero    = nz_upd;

  assign word_fire = b_fire;
  assign word_last = b_last_r;

  always_comb begin
    prev0_nxt     = prev0_r;
    prev1_nxt     = prev1_r;
    prev_miss_nxt = prev_miss_r;
    h0_nxt        = h0_r;
    h1_nxt        = h1_r;
    m_nxt         = m_r;
    nz_nxt        = nz_r;
    if (b_fire) begin
      if (b_last_r) begin
        prev0_nxt     = '0;
        prev1_nxt     = '0;
        prev_miss_nxt = '0;
        h0_nxt        = '0;
        h1_nxt        = '0;
        m_nxt         = '0;
        nz_nxt        = 1'b0;
      end else begin
        if (hit0) prev0_nxt = b_bucket_r;
        if (hit1) prev1_nxt = b_bucket_r;
        if (miss) prev_miss_nxt = b_word_r;
        h0_nxt = h0_upd;
        h1_nxt = h1_upd;
        m_nxt  = m_upd;
        nz_nxt = nz_upd;
      end
    end
  end

  assign b_valid_nxt   = b_take ? a_adv : b_valid_r;
  assign fwd_nxt       = a_adv ? (ram_we && (a_bucket == b_bucket_r)) : fwd_r;
  assign touched_q_nxt = !a_adv                             ? touched_q_r
                       : (b_fire && b_last_r)               ? 1'b0
                       : (ram_we && (a_bucket == b_bucket_r)) ? 1'b1
                       : touched_r[a_bucket];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
      touched_q_r <= 1'b0;
      prev0_r     <= '0;
      prev1_r     <= '0;
      prev_miss_r <= '0;
      h0_r        <= '0;
      h1_r        <= '0;
      m_r         <= '0;
      nz_r        <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      fwd_r       <= fwd_nxt;
      touched_q_r <= touched_q_nxt;
      prev0_r     <= prev0_nxt;
      prev1_r     <= prev1_nxt;
      prev_miss_r <= prev_miss_nxt;
      h0_r        <= h0_nxt;
      h1_r        <= h1_nxt;
      m_r         <= m_nxt;
      nz_r        <= nz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_word_r   <= a_word;
      b_last_r   <= a_last;
      b_bucket_r <= a_bucket;
      fwd_way0_r <= b_word_r;
      fwd_way1_r <= way0;
    end
  end

  // one touched bit per bucket, cleared together at page end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        touched_r[i] <= 1'b0;
      end
    end else if (b_fire) begin
      if (b_last_r) begin
        for (int i = 0; i < NB; i++) begin
          touched_r[i] <= 1'b0;
        end
      end else if (wr) begin
        touched_r[b_bucket_r] <= 1'b1;
      end
    end
  end

endmodule

>>> sv/wkdm_emit.sv
// ----------------------------------------------------------------------------
// wkdm_emit
// Output register with a pending page trailer after the last word.
// ----------------------------------------------------------------------------
module wkdm_emit import wkdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  word_fire,
  input  logic                  word_last,
  input  word_res_t             word_res,
  input  page_sum_t             page_sum,
  output logic                  emit_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [OUT_USER_W-1:0] out_user,
  output logic                  out_last
);

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  pend_r, pend_nxt;
  page_sum_t             pend_sum_r;

  logic                  out_free;
  logic [LEN_SUM_W-1:0]  len;
  logic [LEN_W-1:0]      packed_len;
  logic                  all_zero, too_long;

  assign out_free   = !out_valid_r || out_ready;
  assign emit_ready = out_free && !pend_r;

  assign len = LEN_BASE + LEN_SUM_W'(pend_sum_r.way0_count)
             + LEN_SUM_W'(pend_sum_r.way1_count)
             + {2'b00, pend_sum_r.miss_count, 2'b00};
  assign all_zero   = !pend_sum_r.nonzero;
  assign too_long   = pend_sum_r.nonzero && (len >= LEN_LIMIT);
  assign packed_len = !pend_sum_r.nonzero ? '0
                    : (len > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : len[LEN_W-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    pend_nxt      = pend_r;
    if (out_free) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {too_long, all_zero, packed_len,
                         pend_sum_r.miss_count, pend_sum_r.way1_count,
                         pend_sum_r.way0_count, {WORD_W{1'b0}}, {IDX_CODE_W{1'b0}}};
        out_user_nxt  = {1'b1, TAG_BLANK};
        out_last_nxt  = 1'b1;
        pend_nxt      = 1'b0;
      end else if (word_fire) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {{(OUT_DATA_W - WORD_W - IDX_CODE_W){1'b0}},
                         word_res.miss_code, word_res.index_code};
        out_user_nxt  = {1'b0, word_res.tag};
        out_last_nxt  = !word_last;
        pend_nxt      = word_last;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
    if (word_fire && word_last) begin
      pend_sum_r <= page_sum;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;
  assign out_last  = out_last_r;

endmodule

>>> sv/wkdm_word_classifier_encoder.sv
// ----------------------------------------------------------------------------
// wkdm_word_classifier_encoder
// Page word classifier with two-way hashed dictionary and delta coding.
// ----------------------------------------------------------------------------
// Takes one 32-bit page word per beat and returns one result beat per word,
// plus a trailer beat after the word marked with in_tlast. A word moves
// through three registers: the input register where the word is hashed, the
// dictionary stage that reads a 2**HASH_BITS x 64 RAM (both ways of a bucket
// side by side, a write from the previous word forwarded when it hits the
// same bucket), and the output register. One word is accepted every cycle
// unless out_tready stalls the output; a page end costs an extra output
// beat for its trailer, during which the dictionary stage holds. Each
// bucket has one touched flop, all cleared together at page end; an
// untouched bucket reads as empty, so no clearing pass is needed after
// reset.
module wkdm_word_classifier_encoder import wkdm_pkg::*; #(
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,    // single_way_mode
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [WORD_W-1:0]     in_tdata,       // word_value
  input  logic                  in_tlast,       // page_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // index_code, miss_code, way0_count, way1_count, miss_count,
  // packed_length, all_zero, too_long
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,      // word_tag, is_trailer
  output logic                  out_tlast       // last_result
);

  logic                   single_way_r, single_way_nxt;
  logic                   b_take, a_adv, a_last;
  logic [WORD_W-1:0]      a_word;
  logic [HASH_BITS-1:0]   a_bucket;
  logic [2*WORD_W-1:0]    ram_q, ram_wdata;
  logic                   ram_we;
  logic [HASH_BITS-1:0]   ram_waddr;
  logic                   emit_ready, word_fire, word_last;
  word_res_t              word_res;
  page_sum_t              page_sum;

  assign single_way_nxt = cfg_wr_en ? cfg_wr_data : single_way_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_way_r <= 1'b0;
    end else begin
      single_way_r <= single_way_nxt;
    end
  end

  wkdm_front #(.HASH_BITS(HASH_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_word  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .b_take   (b_take),
    .a_adv    (a_adv),
    .a_word   (a_word),
    .a_last   (a_last),
    .a_bucket (a_bucket)
  );

  wkdm_ram #(
    .WIDTH (2 * WORD_W),
    .DEPTH (2 ** HASH_BITS),
    .AW    (HASH_BITS)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (a_adv),
    .raddr (a_bucket),
    .rdata (ram_q)
  );

  wkdm_classify #(.HASH_BITS(HASH_BITS)) u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .a_adv      (a_adv),
    .a_word     (a_word),
    .a_last     (a_last),
    .a_bucket   (a_bucket),
    .ram_q      (ram_q),
    .single_way (single_way_r),
    .emit_ready (emit_ready),
    .b_take     (b_take),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .word_fire  (word_fire),
    .word_last  (word_last),
    .word_res   (word_res),
    .page_sum   (page_sum)
  );

  wkdm_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_fire  (word_fire),
    .word_last  (word_last),
    .word_res   (word_res),
    .page_sum   (page_sum),
    .emit_ready (emit_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_user   (out_tuser),
    .out_last   (out_tlast)
  );

  // a word beat without tlast is always followed at once by its trailer
  a_trailer_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tuser[2])
    else $error("trailer did not follow last word");

  // trailer carries no word codes
  a_trailer_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == TAG_BLANK
      && out_tdata[WORD_W+IDX_CODE_W-1:0] == '0 && out_tlast)
    else $error("malformed trailer beat");

  // word beats that are not misses carry no miss code
  a_miss_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] && out_tuser[1:0] != TAG_NEW
      |-> out_tdata[WORD_W+IDX_CODE_W-1:IDX_CODE_W] == '0)
    else $error("miss code on non-miss word");

endmodule

>>> tb/wkdm_encoder_checker.sv
// ----------------------------------------------------------------------------
// wkdm_encoder_checker
// Watches the configuration port and both streams of the word classifier.
// Every accepted input beat runs through a cycle-free model of the two-way
// dictionary, the delta coders and the page counters. That model queues the
// word result and, on a page end, the trailer. Each result beat is compared
// field by field with the oldest queued one. The queue depth and the number
// of mismatches go back to the testbench top.
// ----------------------------------------------------------------------------
module wkdm_encoder_checker import wkdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [WORD_W-1:0]     in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  out_tlast,
  output int                    pending,
  output int                    mismatch_count
);

  localparam logic [31:0] GOLDEN_MUL = 32'h9E37_79B1;
  localparam int          PAGE_BASE  = 6 + WORDS_PER_PAGE / 4;
  localparam int          LEN_CAP    = 8191;
  localparam int          LEN_BUDGET = 4096;

  typedef struct packed {
    tag_t        tag;
    logic [7:0]  index_code;
    logic [31:0] miss_code;
    logic        trailer;
    logic [10:0] way0_cnt;
    logic [10:0] way1_cnt;
    logic [10:0] miss_cnt;
    logic [12:0] length;
    logic        all_zero;
    logic        too_long;
    logic        last;
  } enc_beat_t;

  logic [31:0] way0_word [256];
  logic [31:0] way1_word [256];
  logic [1:0]  way_valid [256];
  logic [7:0]  last_idx0;
  logic [7:0]  last_idx1;
  logic [31:0] last_miss;
  logic [10:0] n_hit0;
  logic [10:0] n_hit1;
  logic [10:0] n_miss;
  logic        saw_nonzero;
  logic        one_way;
  enc_beat_t   expected_beats [$];

  initial begin
    pending        = 0;
    mismatch_count = 0;
    one_way        = 1'b0;
  end

  function automatic logic [10:0] sat_inc(input logic [10:0] c);
    return (c == 11'h7FF) ? c : c + 11'd1;
  endfunction

  task automatic clear_page();
    for (int i = 0; i < 256; i++) begin
      way0_word[i] = '0;
      way1_word[i] = '0;
      way_valid[i] = '0;
    end
    last_idx0   = '0;
    last_idx1   = '0;
    last_miss   = '0;
    n_hit0      = '0;
    n_hit1      = '0;
    n_miss      = '0;
    saw_nonzero = 1'b0;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch %s: expected %0h got %0h at %0t", field, want, got, $time);
    mismatch_count++;
  endtask

  task automatic classify_word(input logic [31:0] w, input logic page_end);
    enc_beat_t   wb;
    enc_beat_t   sb;
    logic [31:0] prod;
    logic [7:0]  b;
    int          len;
    wb     = '0;
    wb.tag = TAG_BLANK;
    if (w != '0) begin
      prod        = w * GOLDEN_MUL;
      b           = prod[31:24];
      saw_nonzero = 1'b1;
      if (way_valid[b][0] && way0_word[b] == w) begin
        wb.tag        = TAG_HIT0;
        wb.index_code = b ^ last_idx0;
        last_idx0     = b;
        n_hit0        = sat_inc(n_hit0);
      end else if (!one_way && way_valid[b][1] && way1_word[b] == w) begin
        wb.tag        = TAG_HIT1;
        wb.index_code = b ^ last_idx1;
        last_idx1     = b;
        n_hit1        = sat_inc(n_hit1);
        way1_word[b]  = way0_word[b];
        way0_word[b]  = w;
      end else begin
        wb.tag       = TAG_NEW;
        wb.miss_code = w ^ last_miss;
        last_miss    = w;
        n_miss       = sat_inc(n_miss);
        way1_word[b] = way0_word[b];
        way0_word[b] = w;
        way_valid[b] = {way_valid[b][0], 1'b1};
      end
    end
    wb.last = !page_end;
    expected_beats.push_back(wb);
    if (page_end) begin
      sb          = '0;
      sb.tag      = TAG_BLANK;
      sb.trailer  = 1'b1;
      sb.way0_cnt = n_hit0;
      sb.way1_cnt = n_hit1;
      sb.miss_cnt = n_miss;
      len         = PAGE_BASE + int'(n_hit0) + int'(n_hit1) + 4 * int'(n_miss);
      if (saw_nonzero) begin
        sb.length   = (len > LEN_CAP) ? 13'(LEN_CAP) : 13'(len);
        sb.too_long = (len >= LEN_BUDGET);
      end else begin
        sb.all_zero = 1'b1;
      end
      sb.last = 1'b1;
      expected_beats.push_back(sb);
      clear_page();
    end
  endtask

  task automatic compare_beat(input enc_beat_t want, input enc_beat_t got);
    if (got.tag != want.tag) report_mismatch("word_tag", want.tag, got.tag);
    if (got.index_code != want.index_code)
      report_mismatch("index_code", want.index_code, got.index_code);
    if (got.miss_code != want.miss_code)
      report_mismatch("miss_code", want.miss_code, got.miss_code);
    if (got.trailer != want.trailer) report_mismatch("is_trailer", want.trailer, got.trailer);
    if (got.way0_cnt != want.way0_cnt)
      report_mismatch("way0_count", want.way0_cnt, got.way0_cnt);
    if (got.way1_cnt != want.way1_cnt)
      report_mismatch("way1_count", want.way1_cnt, got.way1_cnt);
    if (got.miss_cnt != want.miss_cnt)
      report_mismatch("miss_count", want.miss_cnt, got.miss_cnt);
    if (got.length != want.length) report_mismatch("packed_length", want.length, got.length);
    if (got.all_zero != want.all_zero)
      report_mismatch("all_zero", want.all_zero, got.all_zero);
    if (got.too_long != want.too_long)
      report_mismatch("too_long", want.too_long, got.too_long);
    if (got.last != want.last) report_mismatch("last_result", want.last, got.last);
  endtask

  always @(posedge clk) begin : monitor
    enc_beat_t got;
    enc_beat_t want;
    if (!rst_n) begin
      clear_page();
      one_way = 1'b0;
      expected_beats.delete();
      pending = 0;
    end else begin
      if (cfg_wr_en) one_way = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got.tag        = out_tuser[1:0];
        got.trailer    = out_tuser[2];
        got.index_code = out_tdata[7:0];
        got.miss_code  = out_tdata[39:8];
        got.way0_cnt   = out_tdata[50:40];
        got.way1_cnt   = out_tdata[61:51];
        got.miss_cnt   = out_tdata[72:62];
        got.length     = out_tdata[85:73];
        got.all_zero   = out_tdata[86];
        got.too_long   = out_tdata[87];
        got.last       = out_tlast;
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", '0, out_tdata[31:0]);
        end else begin
          want = expected_beats.pop_front();
          compare_beat(want, got);
        end
      end
      if (in_tvalid && in_tready) classify_word(in_tdata, in_tlast);
      pending = expected_beats.size();
    end
  end

endmodule

>>> tb/wkdm_word_classifier_encoder_tb.sv
// ----------------------------------------------------------------------------
// wkdm_word_classifier_encoder_tb
// Regression for the page word classifier and encoder.
// ----------------------------------------------------------------------------
// A short directed run comes first. It covers zero words, misses, way-0
// hits, a way-1 hit with its swap, an eviction, a zero page, a page that
// ends on a zero word and single-way mode. Then come four random phases
// that change the mode and the idle pattern on both sides. Their pages are
// built from small pools of words that share buckets, mixed with zeros and
// fresh words, and include one long page past the length budget. A separate
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module wkdm_word_classifier_encoder_tb;
  import wkdm_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic                  cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  int                    pending;
  int                    mismatch_count;
  int                    gap_pct;
  int                    stall_pct;
  logic [31:0]           wx;
  logic [31:0]           wy;
  logic [31:0]           wz;

  wkdm_word_classifier_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  wkdm_encoder_checker enc_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .pending        (pending),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  function automatic logic [7:0] bucket_of(input logic [31:0] w);
    logic [31:0] p;
    p = w * HASH_MUL;
    return p[31:24];
  endfunction

  // another nonzero word landing in the same bucket
  function automatic logic [31:0] bucket_mate(input logic [31:0] w);
    logic [31:0] c;
    do c = $urandom; while (c == '0 || c == w || bucket_of(c) != bucket_of(w));
    return c;
  endfunction

  // valid stays high across back-to-back beats
  task automatic put_word(input logic [31:0] w, input logic page_end);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tlast  <= page_end;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic set_mode(input logic single_way);
    drop_valid();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= single_way;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_pages(input int n_words);
    logic [31:0] pool [$];
    logic [31:0] w;
    int          sent;
    int          len;
    int          r;
    logic        zero_page;
    sent = 0;
    while (sent < n_words) begin
      pool.delete();
      repeat ($urandom_range(1, 3)) begin
        w = $urandom;
        pool.push_back(w);
        repeat ($urandom_range(1, 2)) pool.push_back(bucket_mate(w));
      end
      len       = ($urandom_range(9) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
      zero_page = ($urandom_range(19) == 0);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (zero_page || r < 12) w = '0;
        else if (r < 25) w = $urandom;
        else w = pool[$urandom_range(pool.size() - 1)];
        put_word(w, i == len - 1);
      end
      sent += len;
    end
  endtask

  // mostly fresh words, so nearly every beat is a miss
  task automatic long_page(input int len);
    logic [31:0] w;
    for (int i = 0; i < len; i++) begin
      w = ($urandom_range(99) < 3) ? '0 : $urandom;
      put_word(w, i == len - 1);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b1;
    gap_pct     = 0;
    stall_pct   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_mode(1'b0);
    wx = 32'hFFFF_FFFF;
    wy = bucket_mate(wx);
    do wz = bucket_mate(wx); while (wz == wy);
    put_word('0, 1'b0);
    put_word(wx, 1'b0);
    put_word(32'h0000_0001, 1'b0);
    put_word(32'h8000_0000, 1'b0);
    put_word(wx, 1'b0);
    put_word(wy, 1'b0);
    put_word(wx, 1'b0);
    put_word(wx, 1'b0);
    put_word(wy, 1'b0);
    put_word(wz, 1'b0);
    put_word(wx, 1'b1);
    put_word('0, 1'b0);
    put_word('0, 1'b1);
    put_word(32'h0000_0001, 1'b1);
    put_word(32'h0000_0005, 1'b0);
    put_word('0, 1'b1);
    set_mode(1'b1);
    put_word(wx, 1'b0);
    put_word(wy, 1'b0);
    put_word(wx, 1'b0);
    put_word(wx, 1'b1);

    for (int p = 0; p < 4; p++) begin
      set_mode(p[0]);
      case (p)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 66; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 66; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      run_pages(80);
      if (p == 0) long_page(1020);
    end

    drop_valid();
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/wkdm_pkg.sv
sv/wkdm_ram.sv
sv/wkdm_front.sv
sv/wkdm_classify.sv
sv/wkdm_emit.sv
sv/wkdm_word_classifier_encoder.sv
tb/wkdm_encoder_checker.sv
tb/wkdm_word_classifier_encoder_tb.sv
